// File: rtl/core/mrfc_pkg.sv
package mrfc_pkg;

    // Frame length limits, in bytes, including address and CRC.
    localparam int unsigned MIN_FRAME = 8;
    localparam int unsigned MAX_FRAME = 256;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned CRC_W   = 16;

    // Count value that marks an overlong frame.
    localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(MAX_FRAME + 1);
    localparam logic [COUNT_W-1:0] COUNT_MIN = COUNT_W'(MIN_FRAME);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_FRAME);

    localparam logic [CRC_W-1:0]  CRC_INIT       = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY       = 16'hA001;
    localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'h00;
    localparam logic [BYTE_W-1:0] STATION_RESET  = 8'h01;

    // Configuration port geometry.
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_STATION = 3'h0;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_ADDR_ERR  = 2'd1,
        STATUS_LEN_ERR   = 2'd2,
        STATUS_CRC_ERR   = 2'd3
    } status_t;

    // One byte through the reflected CRC-16/MODBUS polynomial, bit by bit.
    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0]  crc_in,
                                                     input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// File: rtl/core/modbus_rtu_frame_checker_core.sv
// Modbus RTU frame checker: qualifies received frames by address, length and CRC-16.
// Pipeline: an accepted byte waits in the input register and is processed from there; the
// status of a frame is presented on the result channel from the result register, two register stages after input.
// Throughput: one byte per cycle, sustained, as long as results are taken.
// Reset: aresetn is synchronous and active low; it clears the frame state, empties
// both register stages and sets station_address to 1.
module modbus_rtu_frame_checker_core #(
    parameter int unsigned MIN_FRAME = mrfc_pkg::MIN_FRAME,
    parameter int unsigned MAX_FRAME = mrfc_pkg::MAX_FRAME
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Received bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    input  logic        s_tlast,     // frame_end

    // One status request per frame.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [1:0] status, [10:2] frame_length, [15:11] zero
    output logic        m_tuser,     // broadcast

    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mrfc_pkg::PADDR_W-1:0]     paddr,
    input  logic [mrfc_pkg::PDATA_W-1:0]     pwdata,
    output logic [mrfc_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    // Length limits as byte counts; the count saturates one above the maximum.
    localparam logic [mrfc_pkg::COUNT_W-1:0] COUNT_MIN = mrfc_pkg::COUNT_W'(MIN_FRAME);
    localparam logic [mrfc_pkg::COUNT_W-1:0] COUNT_MAX = mrfc_pkg::COUNT_W'(MAX_FRAME);
    localparam logic [mrfc_pkg::COUNT_W-1:0] COUNT_SAT = mrfc_pkg::COUNT_W'(MAX_FRAME + 1);

    // ------------------------------------------------------------------
    // Configuration register. Only the station address exists; writes to
    // any other address are dropped, and reads elsewhere return zero.
    // ------------------------------------------------------------------
    logic [mrfc_pkg::BYTE_W-1:0] station_reg;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_reg <= mrfc_pkg::STATION_RESET;
        end else if (cfg_write && (paddr == mrfc_pkg::ADDR_STATION)) begin
            station_reg <= pwdata[mrfc_pkg::BYTE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == mrfc_pkg::ADDR_STATION) begin
            prdata = {{(mrfc_pkg::PDATA_W - mrfc_pkg::BYTE_W){1'b0}}, station_reg};
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. The input register holds one byte; it is consumed
    // whenever the result register is empty or being drained. Bytes that
    // produce no result are consumed under the same condition, which keeps
    // frame state updates strictly in arrival order.
    // ------------------------------------------------------------------
    logic                        in_valid_reg;
    logic [mrfc_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_last_reg;
    logic                        advance;
    logic                        s_accept;

    logic                        out_valid_reg;
    mrfc_pkg::status_t           status_reg;
    logic [mrfc_pkg::COUNT_W-1:0] length_reg;
    logic                        bcast_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Frame state. The last two bytes sit in a delay line because they are
    // the received CRC; a byte enters the running CRC only when it is pushed
    // out of that line by a newer byte.
    // ------------------------------------------------------------------
    logic [mrfc_pkg::CRC_W-1:0]   crc_reg,   crc_next;
    logic [mrfc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [mrfc_pkg::BYTE_W-1:0]  addr_reg,  addr_next;
    logic [mrfc_pkg::BYTE_W-1:0]  tail0_reg, tail0_next;
    logic [mrfc_pkg::BYTE_W-1:0]  tail1_reg, tail1_next;

    logic                         process;
    mrfc_pkg::status_t            status_next;
    logic                         addr_ok;
    logic                         len_ok;
    logic [mrfc_pkg::CRC_W-1:0]   rx_crc;

    assign process = in_valid_reg && advance;

    always_comb begin
        addr_next  = (count_reg == '0) ? in_byte_reg : addr_reg;
        crc_next   = (count_reg >= mrfc_pkg::COUNT_W'(2))
                   ? mrfc_pkg::crc_update(crc_reg, tail0_reg) : crc_reg;
        tail0_next = tail1_reg;
        tail1_next = in_byte_reg;
        count_next = (count_reg < COUNT_SAT) ? count_reg + 1'b1 : count_reg;

        // CRC travels low byte first, so the newest byte is the high half.
        rx_crc  = {tail1_next, tail0_next};
        addr_ok = (addr_next == station_reg) || (addr_next == mrfc_pkg::BROADCAST_ADDR);
        len_ok  = (count_next >= COUNT_MIN) && (count_next <= COUNT_MAX);

        // Address is checked first, then length, then CRC.
        if (!addr_ok) begin
            status_next = mrfc_pkg::STATUS_ADDR_ERR;
        end else if (!len_ok) begin
            status_next = mrfc_pkg::STATUS_LEN_ERR;
        end else if (crc_next != rx_crc) begin
            status_next = mrfc_pkg::STATUS_CRC_ERR;
        end else begin
            status_next = mrfc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= mrfc_pkg::CRC_INIT;
            count_reg <= '0;
            addr_reg  <= '0;
            tail0_reg <= '0;
            tail1_reg <= '0;
        end else if (process) begin
            if (in_last_reg) begin
                // Frame done: start the next one from a clean state.
                crc_reg   <= mrfc_pkg::CRC_INIT;
                count_reg <= '0;
                addr_reg  <= '0;
                tail0_reg <= '0;
                tail1_reg <= '0;
            end else begin
                crc_reg   <= crc_next;
                count_reg <= count_next;
                addr_reg  <= addr_next;
                tail0_reg <= tail0_next;
                tail1_reg <= tail1_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= process && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process && in_last_reg) begin
            status_reg <= status_next;
            length_reg <= count_next;
            bcast_reg  <= (addr_next == mrfc_pkg::BROADCAST_ADDR);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0_0000, length_reg, status_reg};
    assign m_tuser  = bcast_reg;

`ifndef SYNTHESIS
    // The byte count never runs past its saturation value.
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_SAT)
        else $error("byte count past saturation");

    // A processed last byte leaves the frame state cleared.
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && in_last_reg) |=>
            (count_reg == '0) && (crc_reg == mrfc_pkg::CRC_INIT))
        else $error("frame state not cleared after a frame");

    // A passing frame always has a legal length.
    a_ok_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status_reg == mrfc_pkg::STATUS_OK)) |->
            ((length_reg >= COUNT_MIN) && (length_reg <= COUNT_MAX)))
        else $error("ok status with illegal length");

    // Input stalls only when a byte is held and the result side is blocked.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");
`endif

endmodule

// File: tb/tb_modbus_rtu_frame_checker_core.sv
`timescale 1ns / 1ps

module tb_modbus_rtu_frame_checker_core;

    // Writes to this byte address land on no register and must be ignored.
    localparam logic [mrfc_pkg::PADDR_W-1:0] ADDR_UNUSED = 3'h4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BYTES    = 100;

    // Expected status request for one completed frame.
    typedef struct packed {
        mrfc_pkg::status_t            status;
        logic [mrfc_pkg::COUNT_W-1:0] frame_length;
        logic                         broadcast;
    } frame_status_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;   // [7:0] rx_byte
    logic         s_tlast  = 1'b0;    // frame_end

    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;            // [1:0] status, [10:2] frame_length, [15:11] zero
    logic         m_tuser;            // broadcast

    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [mrfc_pkg::PADDR_W-1:0]  paddr   = '0;
    logic [mrfc_pkg::PDATA_W-1:0]  pwdata  = '0;
    logic [mrfc_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    // Shadow copy of the checker's frame state, advanced once per accepted byte.
    logic [mrfc_pkg::BYTE_W-1:0]  station_shadow = mrfc_pkg::STATION_RESET;
    logic [mrfc_pkg::CRC_W-1:0]   crc_shadow     = mrfc_pkg::CRC_INIT;
    logic [mrfc_pkg::COUNT_W-1:0] count_shadow   = '0;
    logic [mrfc_pkg::BYTE_W-1:0]  addr_shadow    = '0;
    logic [mrfc_pkg::BYTE_W-1:0]  tail_shadow [2] = '{8'h00, 8'h00};

    frame_status_t pending_status_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_sent     = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    modbus_rtu_frame_checker_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    // The result side stalls at random; the rate changes from phase to phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Reflected CRC-16 step: shift out one bit at a time, folding in the
    // polynomial whenever the bit that drops out is set.
    function automatic logic [mrfc_pkg::CRC_W-1:0] crc16_modbus_step(
            input logic [mrfc_pkg::CRC_W-1:0] crc, input logic [7:0] data);
        logic [mrfc_pkg::CRC_W-1:0] acc;
        acc = crc ^ {8'h00, data};
        repeat (8) begin
            acc = (acc >> 1) ^ ({mrfc_pkg::CRC_W{acc[0]}} & 16'hA001);
        end
        return acc;
    endfunction

    // Advance the shadow state by one accepted byte. On the last byte of a
    // frame the expected status request is queued and the frame state clears.
    function automatic void frame_qualify_byte(input logic [7:0] data, input logic last);
        frame_status_t rec;
        if (count_shadow == 0) begin
            addr_shadow = data;
        end
        // The older held byte leaves the two-byte delay line and enters the CRC.
        if (count_shadow >= 2) begin
            crc_shadow = crc16_modbus_step(crc_shadow, tail_shadow[0]);
        end
        tail_shadow[0] = tail_shadow[1];
        tail_shadow[1] = data;
        if (count_shadow < mrfc_pkg::COUNT_SAT) begin
            count_shadow = count_shadow + 1'b1;
        end
        if (last) begin
            // Address first, then length, then CRC; the first failure wins.
            if (addr_shadow != station_shadow && addr_shadow != mrfc_pkg::BROADCAST_ADDR) begin
                rec.status = mrfc_pkg::STATUS_ADDR_ERR;
            end else if (count_shadow < mrfc_pkg::COUNT_MIN ||
                         count_shadow > mrfc_pkg::COUNT_MAX) begin
                rec.status = mrfc_pkg::STATUS_LEN_ERR;
            end else if (crc_shadow != {tail_shadow[1], tail_shadow[0]}) begin
                rec.status = mrfc_pkg::STATUS_CRC_ERR;
            end else begin
                rec.status = mrfc_pkg::STATUS_OK;
            end
            rec.frame_length = count_shadow;
            rec.broadcast    = (addr_shadow == mrfc_pkg::BROADCAST_ADDR);
            pending_status_q.push_back(rec);
            crc_shadow     = mrfc_pkg::CRC_INIT;
            count_shadow   = '0;
            addr_shadow    = '0;
            tail_shadow[0] = 8'h00;
            tail_shadow[1] = 8'h00;
        end
    endfunction

    // Every status request that leaves the block is matched against the
    // oldest expectation, field by field.
    always @(posedge aclk) begin
        frame_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_status_q.size() == 0) begin
                $error("unexpected status request: tdata %h tuser %b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_status_q.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[10:2] !== want.frame_length) begin
                    $error("frame_length: expected %0d, got %0d",
                           want.frame_length, m_tdata[10:2]);
                    fail_count++;
                end
                if (m_tuser !== want.broadcast) begin
                    $error("broadcast: expected %0b, got %0b", want.broadcast, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Ends a run that has hung: nothing moved on any port for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offers one byte, with random idle cycles ahead of it, and waits for the
    // handshake. tvalid stays high into the next byte when no gap follows.
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        frame_qualify_byte(data, last);
        bytes_sent++;
    endtask

    // Builds and sends one frame of total_len bytes. With seal set and room
    // for it, the last two bytes carry the correct CRC, low byte first.
    // fill below zero means random payload, else every payload byte is fill.
    // corrupt flips one bit somewhere after the address byte.
    task automatic send_frame(input logic [7:0] addr, input int total_len,
                              input bit seal, input bit corrupt, input int fill);
        logic [7:0]                 frame_q [$];
        logic [mrfc_pkg::CRC_W-1:0] crc;
        int                         body_len;
        int                         pos;
        bit                         add_crc;
        add_crc  = seal && (total_len >= 3);
        body_len = add_crc ? total_len - 2 : total_len;
        frame_q.push_back(addr);
        while (frame_q.size() < body_len) begin
            frame_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        end
        if (add_crc) begin
            crc = mrfc_pkg::CRC_INIT;
            foreach (frame_q[i]) begin
                crc = crc16_modbus_step(crc, frame_q[i]);
            end
            frame_q.push_back(crc[7:0]);
            frame_q.push_back(crc[15:8]);
        end
        if (corrupt && frame_q.size() > 1) begin
            pos = $urandom_range(frame_q.size() - 1, 1);
            frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(7));
        end
        foreach (frame_q[i]) begin
            send_byte(frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    // Lowers tvalid and waits until every expected request has come, then
    // lets the block settle so that a register write finds it idle.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_status_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [mrfc_pkg::PADDR_W-1:0] addr,
                             input logic [mrfc_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        if (addr == mrfc_pkg::ADDR_STATION) begin
            station_shadow = data[mrfc_pkg::BYTE_W-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reads the station address back and compares it with the shadow copy.
    task automatic check_station_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= mrfc_pkg::ADDR_STATION;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        if (prdata[mrfc_pkg::BYTE_W-1:0] !== station_shadow) begin
            $error("station_address: expected %h, got %h",
                   station_shadow, prdata[mrfc_pkg::BYTE_W-1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_station(input logic [mrfc_pkg::BYTE_W-1:0] value);
        wait_drain();
        apb_write(mrfc_pkg::ADDR_STATION, mrfc_pkg::PDATA_W'(value));
        check_station_readback();
    endtask

    // Directed frames under the reset station address: a good frame, a
    // broadcast frame of all-ones payload, a CRC error, and one-byte frames
    // that fail on address or on length.
    task automatic test_basic_frames();
        send_frame(mrfc_pkg::STATION_RESET, 8, 1'b1, 1'b0, 8'h00);
        send_frame(mrfc_pkg::BROADCAST_ADDR, 8, 1'b1, 1'b0, 8'hFF);
        send_frame(mrfc_pkg::STATION_RESET, 8, 1'b1, 1'b1, -1);
        send_frame(8'hFF, 1, 1'b0, 1'b0, -1);
        send_frame(mrfc_pkg::STATION_RESET, 1, 1'b0, 1'b0, -1);
        send_frame(mrfc_pkg::BROADCAST_ADDR, 1, 1'b0, 1'b0, -1);
    endtask

    // Frame lengths around both limits, including overlong frames whose
    // count saturates while the bytes keep flowing through the CRC.
    task automatic test_length_limits();
        send_frame(mrfc_pkg::STATION_RESET, 2, 1'b0, 1'b0, -1);
        send_frame(mrfc_pkg::STATION_RESET, 7, 1'b1, 1'b0, -1);
        send_frame(mrfc_pkg::STATION_RESET, mrfc_pkg::MIN_FRAME, 1'b1, 1'b0, -1);
        send_frame(mrfc_pkg::BROADCAST_ADDR, mrfc_pkg::MAX_FRAME, 1'b1, 1'b0, -1);
        send_frame(mrfc_pkg::STATION_RESET, mrfc_pkg::MAX_FRAME + 1, 1'b1, 1'b0, -1);
        send_frame(8'h7E, mrfc_pkg::MAX_FRAME + 44, 1'b1, 1'b0, -1);
        send_frame(mrfc_pkg::STATION_RESET, mrfc_pkg::MAX_FRAME + 44, 1'b1, 1'b0, -1);
    endtask

    // Station address at both extremes, and a write to an unused address
    // that must leave the station address alone.
    task automatic test_station_config();
        set_station(8'h00);
        send_frame(mrfc_pkg::BROADCAST_ADDR, 8, 1'b1, 1'b0, -1);
        send_frame(mrfc_pkg::STATION_RESET, 8, 1'b1, 1'b0, -1);
        set_station(8'hFF);
        send_frame(8'hFF, 9, 1'b1, 1'b0, -1);
        send_frame(mrfc_pkg::BROADCAST_ADDR, 8, 1'b1, 1'b1, -1);
        wait_drain();
        apb_write(ADDR_UNUSED, 32'h0000_0055);
        check_station_readback();
        send_frame(8'h55, 8, 1'b1, 1'b0, -1);
        send_frame(8'hFF, 8, 1'b1, 1'b0, -1);
    endtask

    // Mostly well-formed frames with random content, the rest noise. Each
    // phase uses its own station address and its own idling pattern.
    task automatic test_random_traffic();
        int send_pct [4] = '{0, 66, 0, 27};
        int recv_pct [4] = '{0, 0, 66, 27};
        int phase_start;
        int pick;
        int len;
        logic [7:0] addr;
        for (int phase = 0; phase < 4; phase++) begin
            set_station(8'($urandom_range(255)));
            send_idle_pct  = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            phase_start    = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    addr = station_shadow;
                end else if (pick < 70) begin
                    addr = mrfc_pkg::BROADCAST_ADDR;
                end else begin
                    addr = 8'($urandom);
                end
                pick = $urandom_range(99);
                if (pick < 75) begin
                    len = $urandom_range(20, mrfc_pkg::MIN_FRAME);
                end else if (pick < 92) begin
                    len = ($urandom_range(1)) ? $urandom_range(7, 1) : $urandom_range(60, 21);
                end else begin
                    len = $urandom_range(mrfc_pkg::MAX_FRAME + 6, mrfc_pkg::MAX_FRAME - 16);
                end
                if ($urandom_range(99) < 80) begin
                    send_frame(addr, len, 1'b1, ($urandom_range(99) < 20), -1);
                end else begin
                    send_frame(8'($urandom), $urandom_range(12, 1), 1'b0, 1'b0, -1);
                end
                // Now and then the sender holds off until every request is back.
                if ($urandom_range(99) < 5) begin
                    wait_drain();
                end
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_station_readback();
        test_basic_frames();
        test_length_limits();
        test_station_config();
        test_random_traffic();
        wait_drain();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
